// ----- src/u8dec_pkg.sv -----
// u8dec_pkg: constants, types and lead byte decode for utf8_stream_decoder
// no dependencies; imported by utf8_stream_decoder

package u8dec_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned PendW  = 3;
  localparam int unsigned ContW  = 6;

  localparam logic [CountW-1:0] CapacityRst = 16'hFFFF;
  localparam logic [ByteW-1:0]  TermByte    = 8'h00;

  // lead byte thresholds
  localparam logic [ByteW-1:0] Lead6 = 8'hFC;
  localparam logic [ByteW-1:0] Lead5 = 8'hF8;
  localparam logic [ByteW-1:0] Lead4 = 8'hF0;
  localparam logic [ByteW-1:0] Lead3 = 8'hE0;
  localparam logic [ByteW-1:0] Lead2 = 8'hC0;

  // lead payload masks
  localparam logic [ByteW-1:0] Mask6 = 8'h01;
  localparam logic [ByteW-1:0] Mask5 = 8'h03;
  localparam logic [ByteW-1:0] Mask4 = 8'h07;
  localparam logic [ByteW-1:0] Mask3 = 8'h0F;
  localparam logic [ByteW-1:0] Mask2 = 8'h1F;
  localparam logic [ByteW-1:0] ContMask = 8'h3F;

  typedef struct packed {
    logic [PendW-1:0] pend;
    logic [ByteW-1:0] payload;
  } lead_t;

  function automatic lead_t lead_decode(input logic [ByteW-1:0] b);
    lead_t r;
    case (b) inside
      [Lead6:8'hFF]: begin
        r.pend = 3'd5;
        r.payload = b & Mask6;
      end
      [Lead5:Lead6-8'd1]: begin
        r.pend = 3'd4;
        r.payload = b & Mask5;
      end
      [Lead4:Lead5-8'd1]: begin
        r.pend = 3'd3;
        r.payload = b & Mask4;
      end
      [Lead3:Lead4-8'd1]: begin
        r.pend = 3'd2;
        r.payload = b & Mask3;
      end
      [Lead2:Lead3-8'd1]: begin
        r.pend = 3'd1;
        r.payload = b & Mask2;
      end
      default: begin
        r.pend = 3'd0;
        r.payload = b;
      end
    endcase
    return r;
  endfunction

endpackage

// ----- src/utf8_stream_decoder.sv -----
// utf8_stream_decoder: byte-wise utf-8 decoder with character count and capacity limit
// depends on u8dec_pkg
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------
//  in      | sink      | in_valid_i / in_stall_o   | in_byte_i
//  out     | source    | out_valid_o / out_stall_i | code_unit_o stored_o done_res_o
//          |           |                           | char_count_o
//  cfg     | sink      | cfg_we_i                  | cfg_wdata_i (capacity)
//
// one byte per cycle while the output is not stalled: the decode state updates in the
// accept cycle and any result lands in the output register on the same edge
// a byte is taken whenever the output register is empty or being drained
// reset clears the decode state and the output valid; capacity returns to 65535
// a stalled output holds its item and stalls the input side

module utf8_stream_decoder
  import u8dec_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ByteW-1:0]  in_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [UnitW-1:0]  code_unit_o,
  output logic              stored_o,
  output logic              done_res_o,
  output logic [CountW-1:0] char_count_o
);

  logic [CountW-1:0] cap_q;
  logic [UnitW-1:0]  acc_q, acc_d;
  logic [PendW-1:0]  pend_q, pend_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              disc_q, disc_d;

  logic              out_valid_q;
  logic [UnitW-1:0]  code_q, code_d;
  logic              stored_q, stored_d;
  logic              done_q, done_d;
  logic [CountW-1:0] ocnt_q, ocnt_d;
  logic              emit;

  logic              in_acc;
  logic [CountW-1:0] cnt_inc;
  logic [UnitW-1:0]  acc_shift;
  lead_t             lead;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cnt_inc    = cnt_q + 16'd1;
  // only the low 16 bits of the code point are ever seen
  assign acc_shift  = {acc_q[UnitW-ContW-1:0], in_byte_i[ContW-1:0]};
  assign lead       = lead_decode(in_byte_i);

  always_comb begin
    acc_d    = acc_q;
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    disc_d   = disc_q;
    emit     = 1'b0;
    code_d   = '0;
    stored_d = 1'b0;
    done_d   = 1'b0;
    ocnt_d   = cnt_q;
    if (disc_q) begin
      if (in_byte_i == TermByte) begin
        disc_d = 1'b0;
        cnt_d  = '0;
        acc_d  = '0;
        pend_d = '0;
      end
    end else if (in_byte_i == TermByte) begin
      // also abandons a partial character
      emit   = 1'b1;
      done_d = 1'b1;
      cnt_d  = '0;
      acc_d  = '0;
      pend_d = '0;
    end else if (pend_q != '0) begin
      acc_d  = acc_shift;
      pend_d = pend_q - 3'd1;
      if (pend_q == 3'd1) begin
        emit     = 1'b1;
        code_d   = acc_shift;
        stored_d = 1'b1;
      end
    end else begin
      cnt_d  = cnt_inc;
      ocnt_d = cnt_inc;
      if (cnt_inc >= cap_q) begin
        emit   = 1'b1;
        done_d = 1'b1;
        disc_d = 1'b1;
        acc_d  = '0;
        pend_d = '0;
      end else begin
        acc_d  = {{(UnitW-ByteW){1'b0}}, lead.payload};
        pend_d = lead.pend;
        if (lead.pend == '0) begin
          emit     = 1'b1;
          code_d   = {{(UnitW-ByteW){1'b0}}, lead.payload};
          stored_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CapacityRst;
      acc_q  <= '0;
      pend_q <= '0;
      cnt_q  <= '0;
      disc_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        acc_q  <= acc_d;
        pend_q <= pend_d;
        cnt_q  <= cnt_d;
        disc_q <= disc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, loaded with a new item only
  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      code_q   <= code_d;
      stored_q <= stored_d;
      done_q   <= done_d;
      ocnt_q   <= ocnt_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_unit_o  = code_q;
  assign stored_o     = stored_q;
  assign done_res_o   = done_q;
  assign char_count_o = ocnt_q;

`ifndef ASSERT_OFF
  a_stored_xor_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (stored_q != done_q))
    else $error("result item must be either a character or a done item");

  a_done_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> (code_q == '0))
    else $error("done item carries a non-zero code unit");

  a_disc_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> (pend_q == '0))
    else $error("sequence pending while dropping bytes");

  a_disc_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && disc_q) |=> (out_valid_q == $past(out_valid_q && out_stall_i)))
    else $error("item emitted while dropping bytes");
`endif

endmodule
